FILE: rtl/l3d_pkg.sv
// l3d_pkg: shared codes, fixed-point constants and the blend function for
// the 3D LUT pixel mapper. No dependencies.
`default_nettype none

package l3d_pkg;

  // input item kinds
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LUT_READY   = 3'd0,
    REG_MODE        = 3'd1,
    REG_GAIN_FIRST  = 3'd2,
    REG_GAIN_SECOND = 3'd3,
    REG_GAIN_THIRD  = 3'd4
  } cfg_reg_t;

  localparam int ONE_Q16  = 65536;
  localparam int DYE_MAX  = 196608;
  localparam int R3       = 87381;   // floor(2^18 / 3)
  localparam int S3       = 18;
  localparam logic [19:0] OUT_MAX = 20'hFFFFF;

  // (a*(1-f) + b*f) in Q0.16, rounded
  function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                        input logic [16:0] f);
    logic [33:0] s;
    s = 34'(a) * 34'(17'h10000 - f) + 34'(b) * 34'(f) + 34'd32768;
    return s[31:16];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/l3d_bank.sv
// l3d_bank: one parity bank of the node table, one write port and one
// registered read port. Uses no package items.
`default_nettype none

module l3d_bank #(
  parameter int DEPTH = 729,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [47:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [47:0]   rdata
);

  logic [47:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lut3d_trilinear_pixel_map_top.sv
// lut3d_trilinear_pixel_map_top: pipelined trilinear 3D LUT pixel mapper.
// Depends on l3d_pkg and l3d_bank.
//
// Use:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets lut_ready,
//    mode and the three dye gains. cfg_ready is always high; write only
//    while the pipeline is empty.
//  - Input words carry op: a load writes one node, a pixel is mapped.
//    A word is taken when in_valid is high and in_stall low.
//  - Each pixel gives one output word at the last stage; loads give none.
//    One word per clock sustained while out_stall is low, set by the 11-stage
//    pipeline and the eight single-read table banks (one per corner parity).
//  - The table lives in 8 banks of ((N+1)/2)^3 words, split by the parity
//    of the three node coordinates, so the eight corners of a cell are read
//    in the same cycle. Loads write in the same stage that pixels read, so a
//    pixel always sees every load accepted before it.
//  - When out_stall holds the output word, stages fill their empty slots
//    and in_stall rises only once every stage is occupied.
//  - Synchronous reset empties the pipeline and restores the registers;
//    the table is not cleared and needs no clearing pass.
`default_nettype none

module lut3d_trilinear_pixel_map_top
  import l3d_pkg::*;
#(
  parameter int LUT_NODES = 17
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [19:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic [12:0]        node_address,
  input  wire logic [15:0]        node_value0,
  input  wire logic [15:0]        node_value1,
  input  wire logic [15:0]        node_value2,
  input  wire logic signed [19:0] pixel_ch0,
  input  wire logic signed [19:0] pixel_ch1,
  input  wire logic signed [19:0] pixel_ch2,
  input  wire logic               frame_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [19:0]             result_ch0,
  output logic [19:0]             result_ch1,
  output logic [19:0]             result_ch2,
  output logic                    frame_end_out
);

  localparam int N     = LUT_NODES;
  localparam int NW    = $clog2(N);
  localparam int NN    = N * N;
  localparam int NNW   = $clog2(NN);
  localparam int CELLS = N * N * N;
  localparam int H     = (N + 1) / 2;
  localparam int HW    = (H > 1) ? $clog2(H) : 1;
  localparam int H3    = H * H * H;
  localparam int BAW   = (H3 > 1) ? $clog2(H3) : 1;
  localparam int RN    = 8192 / N;
  localparam int RNN   = 8192 / NN;
  localparam int NSTG  = 11;

  // ---------------- configuration ----------------
  logic        lut_ready;
  logic        mode;
  logic [19:0] gain [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lut_ready <= 1'b0;
      mode      <= 1'b0;
      for (int c = 0; c < 3; c++) gain[c] <= 20'(ONE_Q16);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LUT_READY:   lut_ready <= cfg_data[0];
        REG_MODE:        mode      <= cfg_data[0];
        REG_GAIN_FIRST:  gain[0]   <= cfg_data;
        REG_GAIN_SECOND: gain[1]   <= cfg_data;
        REG_GAIN_THIRD:  gain[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [NSTG:1] v;
  logic [NSTG:1] en;
  op_t           op_s6;

  always_comb begin
    en[NSTG] = !v[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) en[k] = !v[k] || en[k+1];
  end

  assign in_stall  = !en[1];
  assign out_valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k] && k != 7) v[k] <= v[k-1];
      end
      // loads leave once written
      if (en[7]) v[7] <= v[6] && (op_s6 == OP_PIXEL);
    end
  end

  // ---------------- stage 1: input word ----------------
  op_t                op_s1;
  logic [12:0]        addr_s1;
  logic [47:0]        val_s1;
  logic signed [19:0] px_s1 [3];
  logic               fe_s1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op_s1    <= op_t'(op);
      addr_s1  <= node_address;
      val_s1   <= {node_value2, node_value1, node_value0};
      px_s1[0] <= pixel_ch0;
      px_s1[1] <= pixel_ch1;
      px_s1[2] <= pixel_ch2;
      fe_s1    <= frame_end;
    end
  end

  // ---------------- stage 2: clamp, /3 estimate, /N^2 estimate ----------------
  logic signed [19:0] ax [3];
  logic [17:0]        cx [3];
  logic [34:0]        p3 [3];
  logic [31:0]        pq1;

  always_comb begin
    ax[0] = mode ? px_s1[2] : px_s1[0];
    ax[1] = px_s1[1];
    ax[2] = mode ? px_s1[0] : px_s1[2];
    for (int k = 0; k < 3; k++) begin
      if (ax[k][19]) begin
        cx[k] = '0;
      end else if (mode) begin
        cx[k] = (ax[k][18:0] > 19'(DYE_MAX)) ? 18'(DYE_MAX) : ax[k][17:0];
      end else begin
        cx[k] = (ax[k][18:0] > 19'(ONE_Q16)) ? 18'(ONE_Q16) : ax[k][17:0];
      end
      p3[k] = 35'(cx[k]) * 35'(R3);
    end
    pq1 = 32'(addr_s1) * 32'(RNN);
  end

  op_t                op_s2;
  logic [12:0]        addr_s2;
  logic [47:0]        val_s2;
  logic signed [19:0] px_s2 [3];
  logic               fe_s2;
  logic [17:0]        cx_s2 [3];
  logic [16:0]        qe_s2 [3];
  logic [12:0]        q1_s2;
  logic               inr_s2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      op_s2   <= op_s1;
      addr_s2 <= addr_s1;
      val_s2  <= val_s1;
      px_s2   <= px_s1;
      fe_s2   <= fe_s1;
      for (int k = 0; k < 3; k++) begin
        cx_s2[k] <= cx[k];
        qe_s2[k] <= p3[k][S3+16:S3];
      end
      q1_s2  <= pq1[25:13];
      inr_s2 <= 32'(addr_s1) < 32'(CELLS);
    end
  end

  // ---------------- stage 3: correct quotients ----------------
  logic [17:0] r3 [3];
  logic [16:0] t   [3];
  logic [31:0] rem1;
  logic [NW-1:0]  a1_n;
  logic [NNW-1:0] rem_n;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r3[k] = cx_s2[k] - {qe_s2[k], 1'b0} - 18'(qe_s2[k]);
      if (mode) begin
        t[k] = (r3[k] >= 18'd3) ? qe_s2[k] + 17'd1 : qe_s2[k];
      end else begin
        t[k] = cx_s2[k][16:0];
      end
    end
    rem1 = 32'(addr_s2) - 32'(q1_s2) * 32'(NN);
    if (rem1 >= 32'(NN)) begin
      a1_n  = NW'(q1_s2 + 13'd1);
      rem_n = NNW'(rem1 - 32'(NN));
    end else begin
      a1_n  = NW'(q1_s2);
      rem_n = NNW'(rem1);
    end
  end

  op_t                op_s3;
  logic [47:0]        val_s3;
  logic signed [19:0] px_s3 [3];
  logic               fe_s3;
  logic [16:0]        t_s3 [3];
  logic [NW-1:0]      a1_s3;
  logic [NNW-1:0]     rem_s3;
  logic               inr_s3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      op_s3  <= op_s2;
      val_s3 <= val_s2;
      px_s3  <= px_s2;
      fe_s3  <= fe_s2;
      t_s3   <= t;
      a1_s3  <= a1_n;
      rem_s3 <= rem_n;
      inr_s3 <= inr_s2;
    end
  end

  // ---------------- stage 4: cell index and fraction ----------------
  logic [31:0]   pp  [3];
  logic [NW-1:0] idx [3];
  logic [16:0]   fr  [3];
  logic [31:0]   pq2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pp[k] = 32'(t_s3[k]) * 32'(N - 1);
      if (pp[k][31:16] > 16'(N - 2)) idx[k] = NW'(N - 2);
      else                           idx[k] = pp[k][16+NW-1:16];
      fr[k] = 17'(pp[k] - (32'(idx[k]) << 16));
    end
    pq2 = (32'(rem_s3) * 32'(RN)) >> 13;
  end

  op_t                op_s4;
  logic [47:0]        val_s4;
  logic signed [19:0] px_s4 [3];
  logic               fe_s4;
  logic [NW-1:0]      idx_s4 [3];
  logic [16:0]        fr_s4 [3];
  logic [NW-1:0]      a1_s4;
  logic [NNW-1:0]     rem_s4;
  logic [NW-1:0]      q2_s4;
  logic               inr_s4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      op_s4  <= op_s3;
      val_s4 <= val_s3;
      px_s4  <= px_s3;
      fe_s4  <= fe_s3;
      idx_s4 <= idx;
      fr_s4  <= fr;
      a1_s4  <= a1_s3;
      rem_s4 <= rem_s3;
      q2_s4  <= NW'(pq2);
      inr_s4 <= inr_s3;
    end
  end

  // ---------------- stage 5: bank coordinates ----------------
  logic [HW-1:0] hc [3][2];
  logic [NW-1:0] co;
  logic [31:0]   rem2;
  logic [NW-1:0] a2_n;
  logic [NW-1:0] a3_n;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int b = 0; b < 2; b++) begin
        // node of parity b among idx and idx+1
        co       = (idx_s4[k][0] == 1'(b)) ? idx_s4[k] : idx_s4[k] + NW'(1);
        hc[k][b] = HW'(co >> 1);
      end
    end
    rem2 = 32'(rem_s4) - 32'(q2_s4) * 32'(N);
    if (rem2 >= 32'(N)) begin
      a2_n = q2_s4 + NW'(1);
      a3_n = NW'(rem2 - 32'(N));
    end else begin
      a2_n = q2_s4;
      a3_n = NW'(rem2);
    end
  end

  op_t                op_s5;
  logic [47:0]        val_s5;
  logic signed [19:0] px_s5 [3];
  logic               fe_s5;
  logic [HW-1:0]      h_s5 [3][2];
  logic [2:0]         par_s5;
  logic [16:0]        fr_s5 [3];
  logic [NW-1:0]      a1_s5, a2_s5, a3_s5;
  logic               inr_s5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      op_s5  <= op_s4;
      val_s5 <= val_s4;
      px_s5  <= px_s4;
      fe_s5  <= fe_s4;
      h_s5   <= hc;
      par_s5 <= {idx_s4[0][0], idx_s4[1][0], idx_s4[2][0]};
      fr_s5  <= fr_s4;
      a1_s5  <= a1_s4;
      a2_s5  <= a2_n;
      a3_s5  <= a3_n;
      inr_s5 <= inr_s4;
    end
  end

  // ---------------- stage 6: bank addresses ----------------
  logic [31:0]    ra32 [8];
  logic [31:0]    wa32;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      ra32[b] = 32'(h_s5[0][b[2]]) * 32'(H * H) + 32'(h_s5[1][b[1]]) * 32'(H)
              + 32'(h_s5[2][b[0]]);
    end
    wa32 = 32'(a1_s5 >> 1) * 32'(H * H) + 32'(a2_s5 >> 1) * 32'(H) + 32'(a3_s5 >> 1);
  end

  logic [47:0]        val_s6;
  logic signed [19:0] px_s6 [3];
  logic               fe_s6;
  logic [BAW-1:0]     ra_s6 [8];
  logic [2:0]         par_s6;
  logic [16:0]        fr_s6 [3];
  logic [2:0]         wb_s6;
  logic [BAW-1:0]     wa_s6;
  logic               inr_s6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      op_s6  <= op_s5;
      val_s6 <= val_s5;
      px_s6  <= px_s5;
      fe_s6  <= fe_s5;
      for (int b = 0; b < 8; b++) ra_s6[b] <= ra32[b][BAW-1:0];
      par_s6 <= par_s5;
      fr_s6  <= fr_s5;
      wb_s6  <= {a1_s5[0], a2_s5[0], a3_s5[0]};
      wa_s6  <= wa32[BAW-1:0];
      inr_s6 <= inr_s5;
    end
  end

  // ---------------- table banks: write and read in the same stage ----------------
  logic [47:0] bank_q [8];
  logic        wr_go;

  assign wr_go = v[6] && (op_s6 == OP_LOAD) && inr_s6 && en[7];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    l3d_bank #(
      .DEPTH(H3),
      .AW   (BAW)
    ) u_bank (
      .clk  (clk),
      .we   (wr_go && (wb_s6 == 3'(b))),
      .waddr(wa_s6),
      .wdata(val_s6),
      .re   (en[7]),
      .raddr(ra_s6[b]),
      .rdata(bank_q[b])
    );
  end

  // ---------------- stage 7: corners in, first axis blend ----------------
  logic signed [19:0] px_s7 [3];
  logic               fe_s7;
  logic [2:0]         par_s7;
  logic [16:0]        fr_s7 [3];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      px_s7  <= px_s6;
      fe_s7  <= fe_s6;
      par_s7 <= par_s6;
      fr_s7  <= fr_s6;
    end
  end

  logic [47:0] corner [8];
  logic [15:0] c_a1 [4][3];

  always_comb begin
    // corner {d1,d2,d3} sits in the bank of parity d ^ idx parity
    for (int d = 0; d < 8; d++) corner[d] = bank_q[3'(d) ^ par_s7];
    for (int j = 0; j < 4; j++) begin
      for (int c = 0; c < 3; c++) begin
        c_a1[j][c] = lerp(corner[{1'b0, 2'(j)}][16*c +: 16],
                          corner[{1'b1, 2'(j)}][16*c +: 16], fr_s7[0]);
      end
    end
  end

  logic signed [19:0] px_s8 [3];
  logic               fe_s8;
  logic [16:0]        fr_s8 [3];
  logic [15:0]        c_s8 [4][3];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      px_s8 <= px_s7;
      fe_s8 <= fe_s7;
      fr_s8 <= fr_s7;
      c_s8  <= c_a1;
    end
  end

  // ---------------- stage 9: second axis ----------------
  logic [15:0] c_a2 [2][3];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int c = 0; c < 3; c++) begin
        c_a2[j][c] = lerp(c_s8[j][c], c_s8[j+2][c], fr_s8[1]);
      end
    end
  end

  logic signed [19:0] px_s9 [3];
  logic               fe_s9;
  logic [16:0]        f3_s9;
  logic [15:0]        c_s9 [2][3];

  always_ff @(posedge clk) begin
    if (en[9]) begin
      px_s9 <= px_s8;
      fe_s9 <= fe_s8;
      f3_s9 <= fr_s8[2];
      c_s9  <= c_a2;
    end
  end

  // ---------------- stage 10: third axis ----------------
  logic signed [19:0] px_s10 [3];
  logic               fe_s10;
  logic [15:0]        v_s10 [3];

  always_ff @(posedge clk) begin
    if (en[10]) begin
      px_s10 <= px_s9;
      fe_s10 <= fe_s9;
      for (int c = 0; c < 3; c++) v_s10[c] <= lerp(c_s9[0][c], c_s9[1][c], f3_s9);
    end
  end

  // ---------------- stage 11: gain, reorder, pass-through ----------------
  logic [36:0] gp  [3];
  logic [19:0] res [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      gp[c] = 37'(v_s10[c]) * 37'(gain[c]) + 37'd32768;
      if (!lut_ready) begin
        res[c] = px_s10[c][19] ? 20'd0 : px_s10[c][19:0];
      end else if (mode) begin
        res[c] = gp[c][36] ? OUT_MAX : gp[c][35:16];
      end else begin
        res[c] = 20'(v_s10[2-c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      result_ch0    <= res[0];
      result_ch1    <= res[1];
      result_ch2    <= res[2];
      frame_end_out <= fe_s10;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/l3d_checker.sv
// l3d_checker: port-level checks for the 3D LUT pixel mapper, bound to the
// top level. Uses no package items.
`default_nettype none

module l3d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [19:0] result_ch0,
  input wire logic        frame_end_out
);

  // held output word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_ch0) && $stable(frame_end_out))
    else $error("output word changed while stalled");

  // input only backs up once the output is stuck
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word after reset");

endmodule

bind lut3d_trilinear_pixel_map_top l3d_checker u_chk (.*);

`default_nettype wire

FILE: verif/tb_top.sv
// tb_top: self-checking bench for the 3D LUT trilinear pixel mapper.
// Depends on l3d_pkg and lut3d_trilinear_pixel_map_top.
`default_nettype none

module tb_top;
  import l3d_pkg::*;

  localparam int NODES = 17;
  localparam int CELLS = NODES * NODES * NODES;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int SETTLE = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_LOAD;
  logic [12:0] node_address = '0;
  logic [15:0] node_value0 = '0, node_value1 = '0, node_value2 = '0;
  logic signed [19:0] pixel_ch0 = '0, pixel_ch1 = '0, pixel_ch2 = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [19:0] result_ch0, result_ch1, result_ch2;
  logic frame_end_out;

  lut3d_trilinear_pixel_map_top #(.LUT_NODES(NODES)) u_top (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic [19:0] ch0, ch1, ch2;
    logic        fe;
  } mapped_px_t;

  // shadow of the block
  logic [15:0] lut_image [CELLS][3];
  logic        sh_ready;
  logic        sh_dye;
  logic [19:0] sh_gain [3];

  mapped_px_t pending_px[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  task automatic report(input string what, input logic [19:0] got, input logic [19:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic int unit_pos(input int x);
    if (x < 0) return 0;
    if (sh_dye) return (x > DYE_MAX ? DYE_MAX : x) / 3;
    return x > ONE_Q16 ? ONE_Q16 : x;
  endfunction

  function automatic int mix(input longint a, input longint b, input longint f);
    return int'((a * (65536 - f) + b * f + 32768) >>> 16);
  endfunction

  function automatic mapped_px_t map_pixel(input logic signed [19:0] p0, p1, p2,
                                           input logic fe);
    mapped_px_t r;
    int px[3];
    int ix[3], fr[3];
    int v[3];
    int p, a, c00, c01, c10, c11, c0, c1;
    longint g;
    px[0] = p0; px[1] = p1; px[2] = p2;
    r.fe = fe;
    if (!sh_ready) begin
      r.ch0 = px[0] < 0 ? 20'd0 : 20'(px[0]);
      r.ch1 = px[1] < 0 ? 20'd0 : 20'(px[1]);
      r.ch2 = px[2] < 0 ? 20'd0 : 20'(px[2]);
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      p = unit_pos(px[sh_dye ? 2 - k : k]) * (NODES - 1);
      ix[k] = p >> 16;
      if (ix[k] > NODES - 2) ix[k] = NODES - 2;
      fr[k] = p - (ix[k] << 16);
    end
    a = (ix[0] * NODES + ix[1]) * NODES + ix[2];
    for (int c = 0; c < 3; c++) begin
      c00 = mix(lut_image[a][c], lut_image[a + NODES*NODES][c], fr[0]);
      c01 = mix(lut_image[a + 1][c], lut_image[a + NODES*NODES + 1][c], fr[0]);
      c10 = mix(lut_image[a + NODES][c], lut_image[a + NODES*NODES + NODES][c], fr[0]);
      c11 = mix(lut_image[a + NODES + 1][c], lut_image[a + NODES*NODES + NODES + 1][c],
                fr[0]);
      c0 = mix(c00, c10, fr[1]);
      c1 = mix(c01, c11, fr[1]);
      v[c] = mix(c0, c1, fr[2]);
    end
    if (sh_dye) begin
      for (int c = 0; c < 3; c++) begin
        g = (longint'(v[c]) * sh_gain[c] + 32768) >>> 16;
        v[c] = g > 1048575 ? 1048575 : int'(g);
      end
      r.ch0 = 20'(v[0]); r.ch1 = 20'(v[1]); r.ch2 = 20'(v[2]);
    end else begin
      r.ch0 = 20'(v[2]); r.ch1 = 20'(v[1]); r.ch2 = 20'(v[0]);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    mapped_px_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        report("unexpected output word", result_ch0, 20'd0);
      end else begin
        w = pending_px.pop_front();
        if (result_ch0 !== w.ch0) report("result_ch0", result_ch0, w.ch0);
        if (result_ch1 !== w.ch1) report("result_ch1", result_ch1, w.ch1);
        if (result_ch2 !== w.ch2) report("result_ch2", result_ch2, w.ch2);
        if (frame_end_out !== w.fe)
          report("frame_end_out", 20'(frame_end_out), 20'(w.fe));
      end
    end
  end

  // one input word; in_valid is left high for a following word
  task automatic send(input op_t kind, input logic [12:0] addr, input logic [15:0] n0, n1, n2,
                      input logic signed [19:0] p0, p1, p2, input logic fe);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    node_address <= addr;
    node_value0 <= n0; node_value1 <= n1; node_value2 <= n2;
    pixel_ch0 <= p0; pixel_ch1 <= p1; pixel_ch2 <= p2;
    frame_end <= fe;
    do @(posedge clk); while (in_stall);
    if (kind == OP_LOAD) begin
      if (addr < CELLS) begin
        lut_image[addr][0] = n0; lut_image[addr][1] = n1; lut_image[addr][2] = n2;
      end
    end else begin
      pending_px.push_back(map_pixel(p0, p1, p2, fe));
    end
  endtask

  task automatic load_node(input logic [12:0] addr, input logic [15:0] n0, n1, n2);
    send(OP_LOAD, addr, n0, n1, n2, 20'($urandom), 20'($urandom), 20'($urandom),
         1'($urandom));
  endtask

  task automatic pixel(input logic signed [19:0] p0, p1, p2);
    send(OP_PIXEL, 13'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
         p0, p1, p2, 1'($urandom));
  endtask

  // wait for the pipeline to empty; loads leave no trace in the queue
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [19:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LUT_READY:   sh_ready = data[0];
      REG_MODE:        sh_dye = data[0];
      REG_GAIN_FIRST:  sh_gain[0] = data;
      REG_GAIN_SECOND: sh_gain[1] = data;
      REG_GAIN_THIRD:  sh_gain[2] = data;
      default: ;
    endcase
  endtask

  function automatic logic signed [19:0] rand_chan();
    case ($urandom_range(9))
      6: return 20'($urandom);
      7: case ($urandom_range(3))
           0: return 20'sd0;
           1: return 20'sd65536;
           2: return 20'sd196608;
           default: return 20'sd65535;
         endcase
      8: return -20'sd1 - 20'($urandom_range(65535));
      9: return 20'sd200000 + 20'($urandom_range(324287));
      default: return 20'($urandom_range(200000));
    endcase
  endfunction

  task automatic test_passthrough();
    cfg_write(REG_LUT_READY, 20'd0);
    pixel(-20'sd524288, 20'sd524287, 20'sd0);
    pixel(-20'sd1, 20'sd65536, 20'sd1);
    pixel(20'sd196608, -20'sd65536, 20'sd524287);
    load_node(13'd0, 16'hFFFF, 16'h0000, 16'h8000);
    send(OP_PIXEL, 13'd0, 16'd0, 16'd0, 16'd0, 20'sd12345, 20'sd0, -20'sd2, 1'b1);
    drain();
  endtask

  task automatic test_table_load();
    load_node(13'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int a = 1; a < CELLS - 1; a++)
      load_node(13'(a), 16'($urandom), 16'($urandom), 16'($urandom));
    load_node(13'(CELLS - 1), 16'h0000, 16'h0000, 16'h0000);
    // addresses past the table are dropped
    load_node(13'(CELLS), 16'h1234, 16'h5678, 16'h9ABC);
    load_node(13'h1FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_exposure();
    cfg_write(REG_LUT_READY, 20'd1);
    cfg_write(REG_MODE, 20'd0);
    pixel(20'sd0, 20'sd0, 20'sd0);
    pixel(20'sd65536, 20'sd65536, 20'sd65536);
    pixel(20'sd65535, 20'sd4096, 20'sd61440);
    pixel(-20'sd524288, 20'sd524287, 20'sd32768);
    pixel(20'sd4095, 20'sd4097, 20'sd12345);
    pixel(20'sd100000, -20'sd1, 20'sd1);
    drain();
  endtask

  task automatic test_dye();
    cfg_write(REG_MODE, 20'd1);
    cfg_write(REG_GAIN_FIRST, 20'hFFFFF);
    cfg_write(REG_GAIN_SECOND, 20'd0);
    cfg_write(REG_GAIN_THIRD, 20'd65536);
    cfg_write(REG_UNUSED, 20'd12345);
    pixel(20'sd196608, 20'sd196608, 20'sd196608);
    pixel(20'sd0, 20'sd0, 20'sd0);
    pixel(20'sd196607, 20'sd98304, 20'sd3);
    pixel(20'sd524287, -20'sd524288, 20'sd65536);
    pixel(20'sd1, 20'sd2, 20'sd150000);
    drain();
  endtask

  task automatic test_random();
    int ph_idle[4] = '{0, 84, 0, 9};
    int ph_stall[4] = '{0, 0, 84, 9};
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = ph_idle[ph % 4];
      stall_pct = ph_stall[ph % 4];
      cfg_write(REG_LUT_READY, 20'($urandom_range(7) != 0));
      cfg_write(REG_MODE, 20'($urandom_range(1)));
      for (int g = 0; g < 3; g++)
        cfg_write(cfg_reg_t'(REG_GAIN_FIRST + g),
                  $urandom_range(3) == 0 ? 20'($urandom) : 20'($urandom_range(98304)));
      for (int n = 0; n < 190; n++) begin
        if ($urandom_range(4) == 0)
          load_node($urandom_range(19) == 0 ? 13'($urandom) : 13'($urandom_range(CELLS - 1)),
                    16'($urandom), 16'($urandom), 16'($urandom));
        else
          pixel(rand_chan(), rand_chan(), rand_chan());
        if (n == 95 && ph == 1) drain();
      end
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();
  endtask

  initial begin
    sh_ready = 1'b0;
    sh_dye = 1'b0;
    for (int g = 0; g < 3; g++) sh_gain[g] = 20'd65536;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_table_load();
    test_exposure();
    test_dye();
    test_random();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
